FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLKRST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// concurrent check on the default clock and reset names
`define ASSERT_DEFAULT(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/brf_pkg.sv
// types, constants and codes for the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

  // store depth must be a power of two and a multiple of the bank count
  localparam int StoreDepth = 1024;
  localparam int NumBanks   = 4;
  localparam int MaxAccess  = 4;
  localparam int PtrW       = $clog2(StoreDepth);
  localparam int BankSelW   = $clog2(NumBanks);
  localparam int RowW       = PtrW - BankSelW;
  localparam int BankRows   = StoreDepth / NumBanks;
  localparam int CntW       = 10;
  localparam int DataW      = 32;
  localparam int CmpW       = ((PtrW > CntW) ? PtrW : CntW) + 1;
  localparam int LaneCntW   = $clog2(MaxAccess + 1);

  typedef enum logic [2:0] {
    ActWrite    = 3'd0,
    ActRead     = 3'd1,
    ActCommit   = 3'd2,
    ActRollback = 3'd3,
    ActSkip     = 3'd4,
    ActClear    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StNoData   = 2'd2,
    StBadCount = 2'd3
  } status_e;

  typedef struct packed {
    action_e          action;
    logic [DataW-1:0] write_data;
    logic [CntW-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    status_e          status;
    logic [CntW-1:0]  readable_count;
    logic [CntW-1:0]  writeable_count;
  } rsp_t;

  // write port and read address of one bank
  typedef struct packed {
    logic            we;
    logic [RowW-1:0] waddr;
    logic [7:0]      wdata;
    logic [RowW-1:0] raddr;
  } bank_ctl_t;

endpackage

FILE: rtl/core/brf_bank.sv
// one byte-wide bank of the ring store, one write and one registered read port
`timescale 1ns / 1ps

module brf_bank import brf_pkg::*; (
  input  logic      clk_i,
  input  bank_ctl_t ctl_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [BankRows];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    rdata_q <= mem[ctl_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/byte_ring_fifo_with_read_commit_top.sv
// top level of the byte ring fifo with speculative read and commit
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte ring fifo with write, speculative read, commit and rollback.
// Request channel: req_i is taken at a rising edge where start is high and
// busy is low. busy is always low, so a request may be issued every cycle.
// Each request carries one action: write or read 0 to 4 bytes (first byte
// most significant), commit, rollback, skip count bytes, or clear.
// Response channel: exactly one response per request, shown on rsp_o for a
// single cycle with done_o high; the request passes the input register, the
// pointer and bank access stage and the result register before done_o rises.
// The receiver cannot stall, so responses are never held back.
// Throughput is one request per clock: all pointer updates are single adds
// and the store is split into four byte banks indexed by address bits
// [1:0], so any four consecutive bytes hit each bank once per cycle.
// A request sees all pointer and store updates of earlier requests.
// Reset clears the three pointers and the pipeline valids; store contents
// are not cleared, and only bytes written since are ever read back.
module byte_ring_fifo_with_read_commit_top import brf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  // stage 1: request register
  logic v1_q;
  req_t req_q;

  // pointers
  logic [PtrW-1:0] wp_q, wp_d;
  logic [PtrW-1:0] rp_q, rp_d;
  logic [PtrW-1:0] cp_q, cp_d;

  // stage 2 results
  logic                v2_q;
  status_e             st_d, st2_q;
  logic [CntW-1:0]     rdc2_q, wrc2_q;
  logic                rd_ok_d, rd_ok2_q;
  logic [LaneCntW-1:0] rd_cnt2_q;
  logic [BankSelW-1:0] rd_off2_q;
  logic                wr_ok;

  // stage 3 output
  logic done_q;
  rsp_t rsp_q;

  logic [PtrW-1:0] readable, writeable, readable_nx, writeable_nx;
  logic            cnt_ok;
  logic [CmpW-1:0] cnt_ext;

  bank_ctl_t  bank_ctl [NumBanks];
  logic [7:0] bank_rdata [NumBanks];
  logic [DataW-1:0] rd_word;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign readable  = wp_q - rp_q;
  assign writeable = cp_q - wp_q - PtrW'(1);
  assign cnt_ext   = CmpW'(req_q.count);
  assign cnt_ok    = req_q.count <= CntW'(MaxAccess);

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    cp_d    = cp_q;
    st_d    = StOk;
    rd_ok_d = 1'b0;
    wr_ok   = 1'b0;
    if (v1_q) begin
      case (req_q.action)
        ActWrite: begin
          if (!cnt_ok) begin
            st_d = StBadCount;
          end else if (cnt_ext > CmpW'(writeable)) begin
            st_d = StNoSpace;
          end else begin
            wr_ok = 1'b1;
            wp_d  = wp_q + PtrW'(req_q.count[LaneCntW-1:0]);
          end
        end
        ActRead: begin
          if (!cnt_ok) begin
            st_d = StBadCount;
          end else if (cnt_ext > CmpW'(readable)) begin
            st_d = StNoData;
          end else begin
            rd_ok_d = 1'b1;
            rp_d    = rp_q + PtrW'(req_q.count[LaneCntW-1:0]);
          end
        end
        ActCommit:   cp_d = rp_q;
        ActRollback: rp_d = cp_q;
        ActSkip: begin
          if (cnt_ext > CmpW'(readable)) begin
            st_d = StNoData;
          end else begin
            rp_d = PtrW'(CmpW'(rp_q) + cnt_ext);
          end
        end
        ActClear: begin
          wp_d = '0;
          rp_d = '0;
          cp_d = '0;
        end
        default: ;
      endcase
    end
  end

  assign readable_nx  = wp_d - rp_d;
  assign writeable_nx = cp_d - wp_d - PtrW'(1);

  // per bank: which lane of the access lands here, and at which row
  always_comb begin
    logic [BankSelW-1:0] wlane, rlane, sh;
    logic [PtrW-1:0]     waddr, raddr;
    for (int b = 0; b < NumBanks; b++) begin
      wlane = BankSelW'(b) - wp_q[BankSelW-1:0];
      rlane = BankSelW'(b) - rp_q[BankSelW-1:0];
      waddr = wp_q + PtrW'(wlane);
      raddr = rp_q + PtrW'(rlane);
      sh    = BankSelW'(req_q.count[LaneCntW-1:0] - LaneCntW'(1) - LaneCntW'(wlane));
      bank_ctl[b].we    = wr_ok && (LaneCntW'(wlane) < req_q.count[LaneCntW-1:0]);
      bank_ctl[b].waddr = waddr[PtrW-1:BankSelW];
      bank_ctl[b].wdata = req_q.write_data[{sh, 3'b000} +: 8];
      bank_ctl[b].raddr = raddr[PtrW-1:BankSelW];
    end
  end

  for (genvar gb = 0; gb < NumBanks; gb++) begin : g_bank
    brf_bank u_bank (
      .clk_i  (clk_i),
      .ctl_i  (bank_ctl[gb]),
      .rdata_o(bank_rdata[gb])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cp_q <= '0;
      v2_q <= 1'b0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cp_q <= cp_d;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st2_q     <= st_d;
    rdc2_q    <= CntW'(readable_nx);
    wrc2_q    <= CntW'(writeable_nx);
    rd_ok2_q  <= rd_ok_d;
    rd_cnt2_q <= req_q.count[LaneCntW-1:0];
    rd_off2_q <= rp_q[BankSelW-1:0];
  end

  // rotate bank outputs into lane order, right aligned on the count
  always_comb begin
    logic [BankSelW-1:0] sel;
    logic [LaneCntW-1:0] sh;
    rd_word = '0;
    for (int i = 0; i < MaxAccess; i++) begin
      sel = rd_off2_q + BankSelW'(i);
      sh  = rd_cnt2_q - LaneCntW'(1) - LaneCntW'(i);
      if (rd_ok2_q && (LaneCntW'(i) < rd_cnt2_q)) begin
        rd_word[{sh[BankSelW-1:0], 3'b000} +: 8] = bank_rdata[sel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.read_data       <= rd_word;
    rsp_q.status          <= st2_q;
    rsp_q.readable_count  <= rdc2_q;
    rsp_q.writeable_count <= wrc2_q;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // read pointer always sits between committed start and write pointer
  `ASSERT_DEFAULT(a_rp_in_window, (PtrW'(rp_q - cp_q) <= PtrW'(wp_q - cp_q)), "read pointer outside window")
  // every accepted request is answered with done_o
  `ASSERT_DEFAULT(a_req_done, ((start && !busy) |-> ##3 done_o), "missing response")
  // no response without a request
  `ASSERT_DEFAULT(a_done_req, (done_o |-> $past(start && !busy, 3)), "response without request")
  // failed accesses return no data
  `ASSERT_DEFAULT(a_err_nodata, ((done_o && rsp_o.status != StOk) |-> (rsp_o.read_data == '0)), "data on failed access")

endmodule
